// File: src/sst_pkg.sv
// shared types and codes of the scoped symbol table
package sst_pkg;

  localparam int SEG_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF  = 32;
  localparam int NUM_SEG       = 4;

  localparam logic [1:0] KIND_DEFINE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_SCOPE  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] SEG_STATIC = 2'd0;
  localparam logic [1:0] SEG_FIELD  = 2'd1;
  localparam logic [1:0] SEG_ARG    = 2'd2;
  localparam logic [1:0] SEG_LOCAL  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] name_key;
    logic [31:0] type_key;
    logic [1:0]  segment;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  found_segment;
    logic [5:0]  found_index;
    logic [31:0] found_type;
    logic [6:0]  segment_count;
  } res_word_t;

  // control part of the search token passed from cell to cell
  typedef struct packed {
    logic       active;
    logic       hit;
    logic [1:0] seg;
  } tok_ctl_t;

  // write strobe broadcast to all cells
  typedef struct packed {
    logic       en;
    logic [1:0] seg;
  } wr_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// File: src/sst_cell.sv
// one entry cell of the search chain
module sst_cell
  import sst_pkg::*;
#(
  parameter int SEG_DEPTH = SEG_DEPTH_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int SEG       = 0,
  parameter int IDX       = 0,
  localparam int IW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1,
  localparam int CW = $clog2(SEG_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  wr_sel_t             wr_sel,
  input  logic [IW-1:0]       wr_idx,
  input  logic [KEY_BITS-1:0] wr_name,
  input  logic [KEY_BITS-1:0] wr_type,
  input  logic [CW-1:0]       seg_count,
  input  tok_ctl_t            ctl_in,
  input  logic [KEY_BITS-1:0] key_in,
  input  logic [KEY_BITS-1:0] type_in,
  input  logic [IW-1:0]       idx_in,
  output tok_ctl_t            ctl_out,
  output logic [KEY_BITS-1:0] key_out,
  output logic [KEY_BITS-1:0] type_out,
  output logic [IW-1:0]       idx_out
);

  logic [KEY_BITS-1:0] name;
  logic [KEY_BITS-1:0] typ;
  logic                match;
  tok_ctl_t            ctl_next;

  always_comb begin
    match = ctl_in.active && !ctl_in.hit && (seg_count > CW'(IDX)) && (name == key_in);
    ctl_next = ctl_in;
    if (match) begin
      ctl_next.hit = 1'b1;
      ctl_next.seg = 2'(SEG);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel.en && wr_sel.seg == 2'(SEG) && wr_idx == IW'(IDX)) begin
      name <= wr_name;
      typ  <= wr_type;
    end
    key_out  <= key_in;
    type_out <= match ? typ : type_in;
    idx_out  <= match ? IW'(IDX) : idx_in;
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

endmodule

// File: src/scoped_symbol_table.sv
// scoped symbol table: four segments held in a chain of entry cells
// define, new-scope and unused words: result registered directly from the taken command
// lookup words: result registered after the search token walks every cell of the chain
// one command in flight; next taken once the last result is registered and skid is empty
// rst (synchronous) empties all segments; stored entries are not cleared
module scoped_symbol_table
  import sst_pkg::*;
#(
  parameter int SEG_DEPTH = SEG_DEPTH_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res
);

  localparam int IW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
  localparam int CW = $clog2(SEG_DEPTH + 1);
  localparam int NC = NUM_SEG * SEG_DEPTH;

  state_t        state, state_next;
  logic [CW-1:0] cnts [NUM_SEG];
  logic [1:0]    seg_q;
  res_word_t     pend;
  logic          pend_valid;

  // chain wiring: position 0 is local index 0, last is static index SEG_DEPTH-1
  tok_ctl_t            ctl  [NC+1];
  logic [KEY_BITS-1:0] key  [NC+1];
  logic [KEY_BITS-1:0] typ  [NC+1];
  logic [IW-1:0]       idx  [NC+1];

  logic                take;
  logic                is_def, is_look, is_scope;
  logic [KEY_BITS-1:0] name_k, type_k;
  logic [CW-1:0]       cur_cnt;
  logic                full;
  wr_sel_t             wr_sel;
  logic                done;
  res_word_t           done_word;

  assign cmd_ready = (state == ST_IDLE) && !pend_valid;
  assign take      = cmd_valid && cmd_ready;
  assign is_def    = cmd.kind == KIND_DEFINE;
  assign is_look   = cmd.kind == KIND_LOOKUP;
  assign is_scope  = cmd.kind == KIND_SCOPE;
  assign name_k    = KEY_BITS'(cmd.name_key);
  assign type_k    = KEY_BITS'(cmd.type_key);
  assign cur_cnt   = cnts[cmd.segment];
  assign full      = cur_cnt >= CW'(SEG_DEPTH);

  assign wr_sel.en  = take && is_def && !full;
  assign wr_sel.seg = cmd.segment;

  // token injection at the head of the chain
  assign ctl[0].active = take && is_look;
  assign ctl[0].hit    = 1'b0;
  assign ctl[0].seg    = SEG_STATIC;
  assign key[0]        = name_k;
  assign typ[0]        = '0;
  assign idx[0]        = '0;

  for (genvar p = 0; p < NC; p++) begin : g_cell
    localparam int CS = NUM_SEG - 1 - p / SEG_DEPTH;
    localparam int CI = p % SEG_DEPTH;
    sst_cell #(
      .SEG_DEPTH (SEG_DEPTH),
      .KEY_BITS  (KEY_BITS),
      .SEG       (CS),
      .IDX       (CI)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_sel    (wr_sel),
      .wr_idx    (cur_cnt[IW-1:0]),
      .wr_name   (name_k),
      .wr_type   (type_k),
      .seg_count (cnts[CS]),
      .ctl_in    (ctl[p]),
      .key_in    (key[p]),
      .type_in   (typ[p]),
      .idx_in    (idx[p]),
      .ctl_out   (ctl[p+1]),
      .key_out   (key[p+1]),
      .type_out  (typ[p+1]),
      .idx_out   (idx[p+1])
    );
  end

  // fsm and result assembly
  always_comb begin
    state_next = state;
    done       = 1'b0;
    done_word  = '0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (is_look) begin
            state_next = ST_SCAN;
          end else begin
            done = 1'b1;
            if (is_def) begin
              done_word.status        = full ? STAT_FULL : STAT_OK;
              done_word.segment_count = full ? 7'(cur_cnt) : 7'(cur_cnt + CW'(1));
            end else if (is_scope) begin
              done_word.segment_count = (cmd.segment == SEG_ARG || cmd.segment == SEG_LOCAL)
                                        ? 7'd0 : 7'(cur_cnt);
            end else begin
              done_word.segment_count = 7'(cur_cnt);
            end
          end
        end
      end
      ST_SCAN: begin
        if (ctl[NC].active) begin
          state_next = ST_IDLE;
          done       = 1'b1;
          done_word.segment_count = 7'(cnts[seg_q]);
          if (ctl[NC].hit) begin
            done_word.status        = STAT_OK;
            done_word.found_segment = ctl[NC].seg;
            done_word.found_index   = 6'(idx[NC]);
            done_word.found_type    = 32'(typ[NC]);
          end else begin
            done_word.status = STAT_MISS;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // segment counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SEG; s++) cnts[s] <= '0;
    end else if (take) begin
      if (is_def && !full) begin
        cnts[cmd.segment] <= cur_cnt + CW'(1);
      end else if (is_scope) begin
        cnts[SEG_ARG]   <= '0;
        cnts[SEG_LOCAL] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seg_q <= cmd.segment;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (done) begin
        if (!res_valid || res_ready) begin
          res       <= done_word;
          res_valid <= 1'b1;
        end else begin
          pend       <= done_word;
          pend_valid <= 1'b1;
        end
      end else if (res_valid && res_ready) begin
        if (pend_valid) begin
          res        <= pend;
          pend_valid <= 1'b0;
        end else begin
          res_valid <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // a token leaves the chain only while a lookup is in progress
  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    ctl[NC].active |-> state == ST_SCAN)
    else $error("search token out of chain while not scanning");

  // skid word only exists behind a held output word
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> res_valid)
    else $error("skid word without output word");

  // no segment ever holds more than its depth
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnts[0] <= CW'(SEG_DEPTH) && cnts[1] <= CW'(SEG_DEPTH) &&
    cnts[2] <= CW'(SEG_DEPTH) && cnts[3] <= CW'(SEG_DEPTH))
    else $error("segment count above depth");

  // a taken lookup always starts a scan
  a_look: assert property (@(posedge clk) disable iff (rst)
    (take && is_look) |=> state == ST_SCAN)
    else $error("lookup did not start a scan");
`endif

endmodule

// File: sim/tb_top.sv
// self-checking testbench of the scoped symbol table
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int DEPTH       = SEG_DEPTH_DEF;
  localparam int LOOKUP_LAT  = 4 * DEPTH + 1;
  localparam int RAND_WORDS  = 1630;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_word_t cmd;
  logic      res_valid;
  logic      res_ready;
  res_word_t res;

  scoped_symbol_table DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shadow copy of the table
  logic [31:0] shadow_name [NUM_SEG][DEPTH];
  logic [31:0] shadow_type [NUM_SEG][DEPTH];
  int          shadow_count [NUM_SEG];

  res_word_t   pending_res [$];
  int          fail_cnt;
  int          cycle_cnt;
  bit          stim_done;
  bit          hold_long;   // receiver holds off while set
  bit          hold_taken;  // first command of the hold-off phase was sent

  // queue one expected result word
  task automatic expect_word(res_word_t r);
    pending_res = {pending_res, r};
  endtask

  // expected result of one command word, updates the shadow table
  function automatic res_word_t table_result(cmd_word_t c);
    res_word_t r;
    bit        hit;
    r   = '0;
    hit = 1'b0;
    case (c.kind)
      KIND_DEFINE: begin
        if (shadow_count[c.segment] >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_name[c.segment][shadow_count[c.segment]] = c.name_key;
          shadow_type[c.segment][shadow_count[c.segment]] = c.type_key;
          shadow_count[c.segment]++;
        end
      end
      KIND_LOOKUP: begin
        r.status = STAT_MISS;
        // local first, static last; lowest index wins
        for (int s = NUM_SEG - 1; s >= 0; s--) begin
          for (int i = 0; i < shadow_count[s]; i++) begin
            if (!hit && shadow_name[s][i] == c.name_key) begin
              hit             = 1'b1;
              r.status        = STAT_OK;
              r.found_segment = 2'(s);
              r.found_index   = 6'(i);
              r.found_type    = shadow_type[s][i];
            end
          end
        end
      end
      KIND_SCOPE: begin
        shadow_count[SEG_ARG]   = 0;
        shadow_count[SEG_LOCAL] = 0;
      end
      default: ;  // unused kind is ignored
    endcase
    r.segment_count = 7'(shadow_count[c.segment]);
    return r;
  endfunction

  // directed rows: typed expectation where obvious, else predictor
  typedef struct {
    cmd_word_t c;
    bit        typed;
    res_word_t r;
  } row_t;

  row_t dir_rows [$];

  function automatic cmd_word_t mk(logic [1:0] k, logic [31:0] n, logic [31:0] t,
                                   logic [1:0] s);
    cmd_word_t c;
    c.kind = k; c.name_key = n; c.type_key = t; c.segment = s;
    return c;
  endfunction

  function automatic res_word_t rw(logic [1:0] st, logic [1:0] fs, logic [5:0] fi,
                                   logic [31:0] ft, logic [6:0] cnt);
    res_word_t r;
    r.status = st; r.found_segment = fs; r.found_index = fi;
    r.found_type = ft; r.segment_count = cnt;
    return r;
  endfunction

  task automatic add_row(cmd_word_t c, bit typed, res_word_t r);
    row_t w;
    w.c = c; w.typed = typed; w.r = r;
    dir_rows = {dir_rows, w};
  endtask

  task automatic build_rows();
    // empty table after reset
    add_row(mk(KIND_LOOKUP, 32'h0, 32'h0, SEG_STATIC), 1,
            rw(STAT_MISS, 2'd0, 6'd0, 32'h0, 7'd0));
    add_row(mk(KIND_DEFINE, 32'h0, 32'hFFFF_FFFF, SEG_STATIC), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd1));
    add_row(mk(KIND_DEFINE, 32'hFFFF_FFFF, 32'h0, SEG_FIELD), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd1));
    add_row(mk(KIND_DEFINE, 32'hFFFF_FFFF, 32'hA5A5_5A5A, SEG_ARG), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd1));
    add_row(mk(KIND_DEFINE, 32'h0, 32'h1234_5678, SEG_LOCAL), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd1));
    // local shadows static, argument shadows field
    add_row(mk(KIND_LOOKUP, 32'h0, 32'hDEAD_BEEF, SEG_FIELD), 1,
            rw(STAT_OK, SEG_LOCAL, 6'd0, 32'h1234_5678, 7'd1));
    add_row(mk(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, SEG_ARG), 1,
            rw(STAT_OK, SEG_ARG, 6'd0, 32'hA5A5_5A5A, 7'd1));
    // unused kind: ignored
    add_row(mk(KIND_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555, SEG_STATIC), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd1));
    // new scope drops argument and local
    add_row(mk(KIND_SCOPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SEG_LOCAL), 1,
            rw(STAT_OK, 2'd0, 6'd0, 32'h0, 7'd0));
    add_row(mk(KIND_LOOKUP, 32'h0, 32'h0, SEG_ARG), 1,
            rw(STAT_OK, SEG_STATIC, 6'd0, 32'hFFFF_FFFF, 7'd0));
    add_row(mk(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, SEG_STATIC), 1,
            rw(STAT_OK, SEG_FIELD, 6'd0, 32'h0, 7'd1));
    add_row(mk(KIND_LOOKUP, 32'h0000_0001, 32'h0, SEG_LOCAL), 1,
            rw(STAT_MISS, 2'd0, 6'd0, 32'h0, 7'd0));
    // duplicate in one segment: lowest index wins
    add_row(mk(KIND_DEFINE, 32'h8000_0000, 32'h11, SEG_LOCAL), 0, '0);
    add_row(mk(KIND_DEFINE, 32'h8000_0000, 32'h22, SEG_LOCAL), 0, '0);
    add_row(mk(KIND_LOOKUP, 32'h8000_0000, 32'h0, SEG_LOCAL), 0, '0);
    add_row(mk(KIND_DEFINE, 32'h7FFF_FFFF, 32'h8000_0001, SEG_FIELD), 0, '0);
    add_row(mk(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0, SEG_FIELD), 0, '0);
    add_row(mk(KIND_UNUSED, 32'h0, 32'h0, SEG_LOCAL), 0, '0);
  endtask

  // ---------------- sender ----------------
  // valid stays high across back-to-back words, dropped only for a gap, the sender pause or the end of the stimulus
  task automatic send_word(cmd_word_t c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // random symbol names from a small pool so lookups and shadowing hit often
  logic [31:0] name_pool [16];

  function automatic cmd_word_t rand_word(int mode);
    cmd_word_t c;
    int        pick;
    c.name_key = $urandom_range(0, 7) == 0 ? $urandom() : name_pool[$urandom_range(0, 15)];
    c.type_key = $urandom();
    c.segment  = 2'($urandom_range(0, 3));
    pick       = $urandom_range(0, 99);
    if (mode == 1) begin
      // fill mode: drives segments to full
      c.kind = pick < 85 ? KIND_DEFINE : KIND_LOOKUP;
    end else if (pick < 40) begin
      c.kind = KIND_DEFINE;
    end else if (pick < 88) begin
      c.kind = KIND_LOOKUP;
    end else if (pick < 96) begin
      c.kind = KIND_SCOPE;
    end else begin
      c.kind = KIND_UNUSED;
    end
    return c;
  endfunction

  initial begin
    cmd_valid = 1'b0;
    cmd       = '0;
    rst       = 1'b1;
    stim_done = 1'b0;
    hold_long = 1'b0;
    hold_taken = 1'b0;
    fail_cnt  = 0;
    for (int s = 0; s < NUM_SEG; s++) shadow_count[s] = 0;
    for (int i = 0; i < 16; i++) name_pool[i] = $urandom();
    name_pool[0] = 32'h0;
    name_pool[1] = 32'hFFFF_FFFF;
    build_rows();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[k]) begin
      res_word_t e;
      e = table_result(dir_rows[k].c);
      if (dir_rows[k].typed && e !== dir_rows[k].r) begin
        $error("directed row %0d: typed %h, predicted %h", k, dir_rows[k].r, e);
        fail_cnt++;
      end
      expect_word(dir_rows[k].typed ? dir_rows[k].r : e);
      send_word(dir_rows[k].c);
    end

    // long receiver hold-off while commands keep coming
    hold_long <= 1'b1;
    for (int n = 0; n < 6; n++) begin
      cmd_word_t c;
      c = rand_word(0);
      expect_word(table_result(c));
      send_word(c);
      if (n == 0) hold_taken = 1'b1;
    end

    // random phases: every third block of 200 words fills segments to full, the other blocks mix all kinds
    for (int n = 0; n < RAND_WORDS; n++) begin
      cmd_word_t c;
      int        mode;
      mode = ((n / 200) % 3 == 1) ? 1 : 0;
      c = rand_word(mode);
      expect_word(table_result(c));
      send_word(c);
      // sender pause until all results are back
      if (n == 800) begin
        cmd_valid <= 1'b0;
        wait (pending_res.size() == 0);
      end
    end
    cmd_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------- receiver ----------------
  initial begin
    int stall;
    res_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (hold_long && hold_taken) begin
        // long hold-off counted here, then released
        stall      = 3 * LOOKUP_LAT;
        hold_long  = 1'b0;
        hold_taken = 1'b0;
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_res.size() == 0) begin
        $error("result word with no expectation: %h", res);
        fail_cnt++;
      end else begin
        res_word_t e;
        e = pending_res.pop_front();
        if (res.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res.status);
          fail_cnt++;
        end
        if (res.found_segment !== e.found_segment) begin
          $error("found_segment: expected %0d, got %0d", e.found_segment, res.found_segment);
          fail_cnt++;
        end
        if (res.found_index !== e.found_index) begin
          $error("found_index: expected %0d, got %0d", e.found_index, res.found_index);
          fail_cnt++;
        end
        if (res.found_type !== e.found_type) begin
          $error("found_type: expected %h, got %h", e.found_type, res.found_type);
          fail_cnt++;
        end
        if (res.segment_count !== e.segment_count) begin
          $error("segment_count: expected %0d, got %0d", e.segment_count, res.segment_count);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------- end of run ----------------
  initial begin
    cycle_cnt = 0;
    fork
      begin
        wait (stim_done);
        wait (pending_res.size() == 0);
        repeat (2 * LOOKUP_LAT) @(posedge clk);
        if (fail_cnt == 0 && pending_res.size() == 0) begin
          $display("*** PASSED ***");
        end else begin
          $display("*** FAILED ***");
        end
        $finish;
      end
      begin
        while (cycle_cnt < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_cnt++;
        end
        $error("timeout, %0d results outstanding", pending_res.size());
        $display("*** FAILED ***");
        $finish;
      end
    join
  end

endmodule
